// ===== rtl/vau_pkg.sv =====
// ----------------------------------------------------------------------------
// vau_pkg
// Opcodes, widths and shared types of the vector arithmetic unit.
// ----------------------------------------------------------------------------
package vau_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 4;
  localparam int ACC_W  = 64;

  localparam logic [OP_W-1:0] OP_ADD   = 4'd0;
  localparam logic [OP_W-1:0] OP_SUB   = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL   = 4'd2;
  localparam logic [OP_W-1:0] OP_DIV   = 4'd3;
  localparam logic [OP_W-1:0] OP_SCALE = 4'd4;
  localparam logic [OP_W-1:0] OP_DIVS  = 4'd5;
  localparam logic [OP_W-1:0] OP_NEG   = 4'd6;
  localparam logic [OP_W-1:0] OP_DOT   = 4'd7;
  localparam logic [OP_W-1:0] OP_NORM  = 4'd8;
  localparam logic [OP_W-1:0] OP_NRMZ  = 4'd9;
  localparam logic [OP_W-1:0] OP_CROSS = 4'd10;
  localparam logic [OP_W-1:0] OP_EQUAL = 4'd11;
  localparam logic [OP_W-1:0] OP_ORTHO = 4'd12;

  localparam int CROSS_DIM = 3;

  localparam logic signed [DATA_W-1:0] SMAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] SMIN = 32'sh80000000;

  typedef struct packed {
    logic [OP_W-1:0]          opcode;
    logic signed [DATA_W-1:0] u_elem;
    logic signed [DATA_W-1:0] v_elem;
    logic signed [DATA_W-1:0] scalar;
    logic                     last_in;
  } in_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     flag;
    logic                     overflow;
    logic                     last_out;
  } out_word_t;

  // saturate a 66-bit signed value to 32 bits
  function automatic logic [DATA_W:0] sat32(input logic signed [65:0] x);
    logic [DATA_W:0] r;
    if (x > 66'sd2147483647) r = {1'b1, SMAX};
    else if (x < -66'sd2147483648) r = {1'b1, SMIN};
    else r = {1'b0, x[DATA_W-1:0]};
    return r;
  endfunction

endpackage

// ===== rtl/vau_if.sv =====
// ----------------------------------------------------------------------------
// vau_in_if / vau_out_if
// Valid/ready channels of the vector arithmetic unit.
// ----------------------------------------------------------------------------
interface vau_in_if import vau_pkg::*; ();
  logic     valid;
  logic     ready;
  in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vau_out_if import vau_pkg::*; ();
  logic      valid;
  logic      ready;
  out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/vau_div.sv =====
// ----------------------------------------------------------------------------
// vau_div
// Iterative restoring divider and square root, one bit per cycle.
// div: q = trunc((a << FRAC_BITS) / b), saturated; sqrt: floor(sqrt(x)).
// ----------------------------------------------------------------------------
module vau_div import vau_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic                     is_sqrt,
  input  logic signed [DATA_W-1:0] a,
  input  logic signed [DATA_W-1:0] b,
  input  logic [ACC_W-1:0]         x,
  output logic                     done,
  output logic signed [DATA_W-1:0] res,
  output logic                     ovf
);
  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int QB = NUM_W;   // quotient bits for division
  localparam int SB = ACC_W/2; // result bits for sqrt

  logic                 busy_r, busy_nxt;
  logic                 sq_r;
  logic [6:0]           cnt_r;
  logic [ACC_W-1:0]     num_r;    // dividend bits, or radicand
  logic [ACC_W+1:0]     rem_r;
  logic [ACC_W-1:0]     q_r;
  logic [DATA_W-1:0]    den_r;
  logic                 neg_r;
  logic                 done_r;

  logic [ACC_W+1:0] trial;
  logic [ACC_W+1:0] shifted;
  logic [NUM_W-1:0] mag_a;

  assign mag_a = NUM_W'(a[DATA_W-1] ? -{{FRAC_BITS{a[DATA_W-1]}}, a}
                                    : {{FRAC_BITS{1'b0}}, a})
                 << FRAC_BITS;

  always_comb begin
    if (sq_r) begin
      shifted = {rem_r[ACC_W-1:0], num_r[ACC_W-1:ACC_W-2]};
      trial   = {q_r[ACC_W-1:0], 2'b01};
    end else begin
      shifted = {rem_r[ACC_W:0], num_r[ACC_W-1]};
      trial   = (ACC_W+2)'(den_r);
    end
  end

  assign busy_nxt = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        sq_r   <= is_sqrt;
        rem_r  <= '0;
        q_r    <= '0;
        if (is_sqrt) begin
          num_r <= x;
          cnt_r <= 7'(SB);
          neg_r <= 1'b0;
        end else begin
          num_r <= {mag_a, {(ACC_W-NUM_W){1'b0}}};
          cnt_r <= 7'(QB);
          den_r <= b[DATA_W-1] ? -b : b;
          neg_r <= a[DATA_W-1] ^ b[DATA_W-1];
        end
      end else if (busy_nxt) begin
        num_r <= sq_r ? {num_r[ACC_W-3:0], 2'b00} : {num_r[ACC_W-2:0], 1'b0};
        if (shifted >= trial) begin
          rem_r <= shifted - trial;
          q_r   <= {q_r[ACC_W-2:0], 1'b1};
        end else begin
          rem_r <= shifted;
          q_r   <= {q_r[ACC_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  logic signed [65:0] sq;
  logic [DATA_W:0]    sat;
  assign sq  = neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
  assign sat = sat32(sq);

  always_comb begin
    done = done_r;
    if (sq_r) begin
      ovf = q_r > ACC_W'(SMAX);
      res = ovf ? SMAX : q_r[DATA_W-1:0];
    end else begin
      ovf = sat[DATA_W];
      res = sat[DATA_W-1:0];
    end
  end
endmodule

// ===== rtl/vau_mem.sv =====
// ----------------------------------------------------------------------------
// vau_mem
// Element buffer: u and v in one synchronous memory, one read a cycle.
// ----------------------------------------------------------------------------
module vau_mem import vau_pkg::*; #(
  parameter int MAX_DIM = 16,
  parameter int AW = 4
) (
  input  logic                clk,
  input  logic                we,
  input  logic [AW-1:0]       waddr,
  input  logic [2*DATA_W-1:0] wdata,
  input  logic [AW-1:0]       raddr,
  output logic [2*DATA_W-1:0] rdata
);
  logic [2*DATA_W-1:0] mem [MAX_DIM];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/vector_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// vector_arithmetic_unit
// One word in work at a time. add/sub/mul/scale/negate: result registered in EXEC,
// shown from OUT, and a new word is taken only after it is accepted; dot/equal/orthogonal
// answer from FIN after the last word. div/divscalar: 48-step divider, result via DIVW.
// Norm: square root started on the last word; normalize divides each element by the norm
// (passes it unchanged when the norm is zero); cross: terms via CMUL and CSUB.
// Reset (synchronous, active low) clears control and the accumulator.
// ----------------------------------------------------------------------------
module vector_arithmetic_unit import vau_pkg::*; #(
  parameter int MAX_DIM   = 16,
  parameter int FRAC_BITS = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  vau_in_if.sink    in_ch,
  vau_out_if.source out_ch
);
  localparam int AW = $clog2(MAX_DIM);
  localparam int CW = $clog2(MAX_DIM + 2);

  localparam logic [3:0] S_IDLE = 4'd0, S_EXEC = 4'd1, S_DIVW = 4'd2,
                         S_OUT = 4'd3, S_SQW = 4'd4, S_NRD = 4'd5,
                         S_NDIV = 4'd6, S_CRD = 4'd7, S_CMUL = 4'd8,
                         S_CSUB = 4'd9, S_FIN = 4'd10;

  logic [3:0]               st_r;
  in_word_t                 w_r;
  logic [OP_W-1:0]          op_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [CW-1:0]            cnt_r;
  logic                     eq_r;
  out_word_t                o_r;
  logic                     ov_r;   // out valid
  logic                     endv_r; // end of vector after output
  logic [3:0]               ret_r;  // state after output
  logic [AW-1:0]            ri_r;   // read index
  logic [CW-1:0]            m_r;
  logic signed [DATA_W-1:0] nrm_r;
  logic [1:0]               ci_r;
  logic signed [DATA_W-1:0] ca_r [3];
  logic signed [DATA_W-1:0] cb_r [3];
  logic signed [ACC_W-1:0]  p1_r, p2_r;

  // memory
  logic                mwe;
  logic [AW-1:0]       mra;
  logic [2*DATA_W-1:0] mrd;
  vau_mem #(.MAX_DIM(MAX_DIM), .AW(AW)) u_mem (
    .clk(clk), .we(mwe), .waddr(cnt_r[AW-1:0]),
    .wdata({w_r.u_elem, w_r.v_elem}), .raddr(mra), .rdata(mrd));

  // divider
  logic                     d_start, d_sqrt, d_done, d_ovf;
  logic signed [DATA_W-1:0] d_a, d_b, d_res;
  logic signed [ACC_W-1:0]  acc_fwd;
  vau_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .start(d_start), .is_sqrt(d_sqrt), .a(d_a), .b(d_b),
    .x(acc_fwd[ACC_W-1] ? '0 : acc_fwd), .done(d_done), .res(d_res), .ovf(d_ovf));

  logic [OP_W-1:0] op;
  assign op = (cnt_r == '0) ? w_r.opcode : op_r;

  assign in_ch.ready = (st_r == S_IDLE);
  assign out_ch.valid = ov_r;
  assign out_ch.data  = o_r;

  // element arithmetic
  logic signed [ACC_W-1:0] prod, sqr, prod_b;
  logic signed [65:0]      sh;
  logic [DATA_W:0]         sat;
  logic signed [ACC_W:0]   asum;
  logic signed [ACC_W-1:0] anew;
  logic signed [DATA_W-1:0] mb;
  logic                    acc_upd;
  assign mb     = (op == OP_SCALE || op == OP_DIVS) ? w_r.scalar : w_r.v_elem;
  assign prod   = w_r.u_elem * mb;
  assign sqr    = w_r.u_elem * w_r.u_elem;
  assign prod_b = (op == OP_DOT || op == OP_ORTHO) ? prod : sqr;
  assign asum   = {acc_r[ACC_W-1], acc_r} + {prod_b[ACC_W-1], prod_b};
  assign anew   = (asum[ACC_W] != asum[ACC_W-1]) ?
                  (asum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}})
                  : asum[ACC_W-1:0];
  assign acc_upd = (op == OP_DOT || op == OP_ORTHO || op == OP_NORM ||
                    (op == OP_NRMZ && cnt_r < CW'(MAX_DIM)));
  // square root starts on the last word, so it sees the sum including that word
  assign acc_fwd = (st_r == S_EXEC && acc_upd) ? anew : acc_r;

  always_comb begin
    sh = '0;
    case (op)
      OP_ADD: sh = 66'(w_r.u_elem) + 66'(w_r.v_elem);
      OP_SUB: sh = 66'(w_r.u_elem) - 66'(w_r.v_elem);
      OP_NEG: sh = -66'(w_r.u_elem);
      OP_MUL, OP_SCALE: sh = 66'(prod >>> FRAC_BITS);
      OP_DOT: sh = 66'(acc_r >>> FRAC_BITS);
      default: sh = '0;
    endcase
  end
  assign sat = sat32(sh);

  logic signed [ACC_W-1:0] cdiff;
  logic [DATA_W:0]         csat;
  assign cdiff = p1_r - p2_r;
  assign csat  = sat32(66'(cdiff >>> FRAC_BITS));

  always_comb begin
    d_start = 1'b0; d_sqrt = 1'b0; d_a = w_r.u_elem; d_b = mb;
    mra = ri_r;
    if (st_r == S_EXEC && (op == OP_DIV || op == OP_DIVS)) d_start = 1'b1;
    if (st_r == S_EXEC && w_r.last_in && (op == OP_NORM || op == OP_NRMZ)) begin
      d_start = 1'b1; d_sqrt = 1'b1;
    end
    if (st_r == S_NRD && ci_r == 2'd1 && nrm_r != '0) begin
      d_start = 1'b1; d_a = mrd[2*DATA_W-1:DATA_W]; d_b = nrm_r;
    end
    mwe = (st_r == S_EXEC) && (op == OP_NRMZ || op == OP_CROSS)
          && (cnt_r < CW'(MAX_DIM));
  end

  logic [CW-1:0] cnt_inc;
  assign cnt_inc = (cnt_r <= CW'(MAX_DIM)) ? cnt_r + 1'b1 : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; acc_r <= '0; cnt_r <= '0; eq_r <= 1'b1; op_r <= '0;
      ov_r <= 1'b0; endv_r <= 1'b0; ret_r <= S_IDLE; ci_r <= '0; ri_r <= '0;
    end else begin
      if (ov_r && out_ch.ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: if (in_ch.valid) begin
          w_r <= in_ch.data; st_r <= S_EXEC;
        end
        S_EXEC: begin
          op_r  <= op;
          cnt_r <= cnt_inc;
          endv_r <= w_r.last_in;
          if (acc_upd) acc_r <= anew;
          if (op == OP_EQUAL && w_r.u_elem != w_r.v_elem) eq_r <= 1'b0;
          o_r <= '{value: sat[DATA_W-1:0], flag: 1'b0, overflow: sat[DATA_W],
                   last_out: w_r.last_in};
          ret_r <= w_r.last_in ? S_FIN : S_IDLE;
          ri_r <= '0;
          ci_r <= '0;
          case (op)
            OP_ADD, OP_SUB, OP_NEG, OP_MUL, OP_SCALE: st_r <= S_OUT;
            OP_DIV, OP_DIVS: st_r <= S_DIVW;
            OP_NORM, OP_NRMZ: st_r <= w_r.last_in ? S_SQW : S_IDLE;
            OP_CROSS: st_r <= w_r.last_in ? S_CRD : S_IDLE;
            default: st_r <= w_r.last_in ? S_FIN : S_IDLE;
          endcase
          if (w_r.last_in) m_r <= (cnt_inc < CW'(MAX_DIM)) ? cnt_inc : CW'(MAX_DIM);
        end
        S_DIVW: if (d_done) begin
          o_r.value <= d_res; o_r.overflow <= d_ovf; st_r <= S_OUT;
        end
        S_SQW: if (d_done) begin
          nrm_r <= d_res;
          if (op_r == OP_NORM) begin
            o_r <= '{value: d_res, flag: 1'b0, overflow: d_ovf, last_out: 1'b1};
            st_r <= S_OUT;
          end else begin
            ri_r <= '0; ci_r <= '0; st_r <= S_NRD;
          end
        end
        S_NRD: begin
          // wait for the registered read data, then start the divide unless the norm is zero
          if (ci_r == 2'd1) begin
            ci_r <= '0;
            o_r <= '{value: mrd[2*DATA_W-1:DATA_W], flag: 1'b0, overflow: 1'b0,
                     last_out: (CW'(ri_r) + 1'b1 == m_r)};
            st_r <= (nrm_r != '0) ? S_NDIV : S_OUT;
            ret_r <= (CW'(ri_r) + 1'b1 == m_r) ? S_FIN : S_NRD;
            ri_r <= ri_r + 1'b1;
          end else begin
            ci_r <= ci_r + 2'd1;
          end
        end
        S_NDIV: if (d_done) begin
          o_r.value <= d_res; o_r.overflow <= d_ovf; st_r <= S_OUT;
        end
        S_CRD: begin
          if (cnt_r != CW'(CROSS_DIM)) begin
            o_r <= '{value: '0, flag: 1'b0, overflow: 1'b1, last_out: 1'b1};
            st_r <= S_OUT;
          end else begin
            ri_r <= ri_r + 1'b1;
            if (ri_r != '0) begin
              ca_r[2'(ri_r - 1'b1)] <= mrd[2*DATA_W-1:DATA_W];
              cb_r[2'(ri_r - 1'b1)] <= mrd[DATA_W-1:0];
            end
            if (ri_r == AW'(CROSS_DIM)) begin ci_r <= '0; st_r <= S_CMUL; end
          end
        end
        S_CMUL: begin
          case (ci_r)
            2'd0: begin p1_r <= ca_r[1]*cb_r[2]; p2_r <= ca_r[2]*cb_r[1]; end
            2'd1: begin p1_r <= ca_r[2]*cb_r[0]; p2_r <= ca_r[0]*cb_r[2]; end
            default: begin p1_r <= ca_r[0]*cb_r[1]; p2_r <= ca_r[1]*cb_r[0]; end
          endcase
          st_r <= S_CSUB;
        end
        S_CSUB: begin
          o_r <= '{value: csat[DATA_W-1:0], flag: 1'b0, overflow: csat[DATA_W],
                   last_out: (ci_r == 2'd2)};
          ret_r <= (ci_r == 2'd2) ? S_FIN : S_CMUL;
          ci_r <= ci_r + 2'd1;
          st_r <= S_OUT;
        end
        // hold here until the word is taken, so o_r is free afterwards
        S_OUT: begin
          if (!ov_r) ov_r <= 1'b1;
          else if (out_ch.ready) st_r <= ret_r;
        end
        S_FIN: if (!ov_r) begin
          // dot/equal/orthogonal emit on the first pass and clear on the second; others clear at once
          if (ret_r == S_FIN) begin
            case (op_r)
              OP_DOT: begin
                o_r <= '{value: sat[DATA_W-1:0], flag: 1'b0, overflow: sat[DATA_W],
                         last_out: 1'b1};
                ov_r <= 1'b1;
              end
              OP_EQUAL: begin
                o_r <= '{value: '0, flag: eq_r, overflow: 1'b0, last_out: 1'b1};
                ov_r <= 1'b1;
              end
              OP_ORTHO: begin
                o_r <= '{value: '0, flag: (acc_r == '0), overflow: 1'b0, last_out: 1'b1};
                ov_r <= 1'b1;
              end
              default: ;
            endcase
          end
          if (!endv_r) st_r <= S_IDLE;
          else begin
            if (!(op_r == OP_DOT || op_r == OP_EQUAL || op_r == OP_ORTHO)
                || ret_r == S_IDLE) begin
              acc_r <= '0; cnt_r <= '0; eq_r <= 1'b1; st_r <= S_IDLE;
            end
            ret_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  // checks
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result dropped while stalled");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !in_ch.ready) else $error("ready while busy");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_DIM + 1)) else $error("element count overrun");
endmodule
